@@ sv/prbs_byte_generator_checker_defines.svh @@
// Assertion macros for the PRBS byte generator/checker.
// No dependencies; included by modules that carry assertions.
`ifndef PRBS_BYTE_GENERATOR_CHECKER_DEFINES_SVH
`define PRBS_BYTE_GENERATOR_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset
`define PBGC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included
`define PBGC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBGC_ASSERT(label, prop, msg)
`define PBGC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ sv/prbs_bgc_pkg.sv @@
// Package for the PRBS byte generator/checker: transfer types, register
// map and the LFSR/popcount helper functions. No dependencies.
`timescale 1ns / 1ps

package prbs_bgc_pkg;

    localparam int unsigned ShiftWidth = 32;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned CountWidth = 4;
    localparam int unsigned SeedWidth  = 3;
    localparam int unsigned AddrWidth  = 4;
    localparam int unsigned DataWidth  = 32;

    localparam logic [SeedWidth-1:0] SEED_BYTES = 3'd4;

    localparam logic [ShiftWidth-1:0] TAP_MASK_RESET = 32'h0012_0000;
    localparam logic [ByteWidth-1:0]  BYTE_MASK      = 8'hff;

    // Register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_TAP_MASK    = 2'd0,
        REG_INVERT_MASK = 2'd1,
        REG_CHECK_MODE  = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [ByteWidth-1:0] rx_byte;
        logic                 start_req;
    } item_t;

    typedef struct packed {
        logic [ByteWidth-1:0]  data_byte;
        logic [CountWidth-1:0] byte_errors;
        logic [ShiftWidth-1:0] error_total;
        logic                  seeding;
    } result_t;

    // Eight shifts; each feeds in the parity of (register & taps)
    function automatic logic [ShiftWidth-1:0] lfsr_step(
        input logic [ShiftWidth-1:0] r,
        input logic [ShiftWidth-1:0] taps
    );
        logic [ShiftWidth-1:0] v;
        v = r;
        for (int i = 0; i < ByteWidth; i++) begin
            v = {v[ShiftWidth-2:0], ^(v & taps)};
        end
        return v;
    endfunction

    // Smallest all-ones value not below the taps: smear the top set bit down
    function automatic logic [ShiftWidth-1:0] ones_fill(
        input logic [ShiftWidth-1:0] taps
    );
        logic [ShiftWidth-1:0] v;
        v = taps;
        v = v | (v >> 1);
        v = v | (v >> 2);
        v = v | (v >> 4);
        v = v | (v >> 8);
        v = v | (v >> 16);
        return v;
    endfunction

    function automatic logic [CountWidth-1:0] popcount8(
        input logic [ByteWidth-1:0] v
    );
        logic [CountWidth-1:0] n;
        n = '0;
        for (int i = 0; i < ByteWidth; i++) begin
            n = n + CountWidth'(v[i]);
        end
        return n;
    endfunction

endpackage

@@ sv/prbs_byte_generator_checker.sv @@
// Pipeline: an accepted input is held in the input stage register, then written
// to the result register when that is empty or being taken (result_ready), and
// transfers from there. Throughput: one item per cycle while result_ready is high;
// the limit is the eight-shift LFSR XOR network between the two registers.
// Reset (rst_n low, asynchronous): pipeline emptied, LFSR, seed count and
// error total cleared, registers back to their defaults (taps 0x00120000).
`timescale 1ns / 1ps
`include "prbs_byte_generator_checker_defines.svh"

module prbs_byte_generator_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input items
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  prbs_bgc_pkg::item_t                  item,
    // results
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output prbs_bgc_pkg::result_t                result,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [prbs_bgc_pkg::AddrWidth-1:0]   paddr,
    input  logic [prbs_bgc_pkg::DataWidth-1:0]   pwdata,
    output logic [prbs_bgc_pkg::DataWidth-1:0]   prdata,
    output logic                                 pready
);

    // Configuration registers
    logic [prbs_bgc_pkg::ShiftWidth-1:0] tap_mask_reg;
    logic [prbs_bgc_pkg::ByteWidth-1:0]  invert_mask_reg;
    logic                                check_mode_reg;

    // Sequence state
    logic [prbs_bgc_pkg::ShiftWidth-1:0] shift_reg, shift_next;
    logic [prbs_bgc_pkg::SeedWidth-1:0]  seed_count_reg, seed_count_next;
    logic [prbs_bgc_pkg::ShiftWidth-1:0] total_reg, total_next;

    // Pipeline
    logic                  stage_valid_reg;
    prbs_bgc_pkg::item_t   stage_reg;
    logic                  result_valid_reg;
    prbs_bgc_pkg::result_t result_reg, result_next;

    logic                          load;
    logic                          cfg_write;
    prbs_bgc_pkg::reg_index_t      cfg_index;
    logic [prbs_bgc_pkg::ByteWidth-1:0]  masked;
    logic [prbs_bgc_pkg::ShiftWidth-1:0] stepped;
    logic [prbs_bgc_pkg::CountWidth-1:0] errs;
    logic [prbs_bgc_pkg::ShiftWidth:0]   sum;
    logic [prbs_bgc_pkg::ShiftWidth-1:0] base_total;

    // Handshake
    assign load         = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !stage_valid_reg || load;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_index = prbs_bgc_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_index)
            prbs_bgc_pkg::REG_TAP_MASK:    prdata = tap_mask_reg;
            prbs_bgc_pkg::REG_INVERT_MASK: prdata = 32'(invert_mask_reg);
            prbs_bgc_pkg::REG_CHECK_MODE:  prdata = 32'(check_mode_reg);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_mask_reg    <= prbs_bgc_pkg::TAP_MASK_RESET;
            invert_mask_reg <= '0;
            check_mode_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                prbs_bgc_pkg::REG_TAP_MASK:    tap_mask_reg    <= pwdata;
                prbs_bgc_pkg::REG_INVERT_MASK: invert_mask_reg <= pwdata[7:0];
                prbs_bgc_pkg::REG_CHECK_MODE:  check_mode_reg  <= pwdata[0];
                default:                       ;
            endcase
        end
    end

    // Per-byte generate/check logic
    always_comb
    begin
        masked          = stage_reg.rx_byte ^ invert_mask_reg;
        base_total      = stage_reg.start_req ? '0 : total_reg;
        shift_next      = shift_reg;
        seed_count_next = seed_count_reg;
        total_next      = base_total;
        errs            = '0;
        stepped         = prbs_bgc_pkg::lfsr_step(shift_reg, tap_mask_reg);
        sum             = '0;
        result_next.seeding = 1'b0;

        if (!check_mode_reg)
        begin
            // generate: optional fill, then one byte step
            if (stage_reg.start_req)
                shift_next = prbs_bgc_pkg::lfsr_step(
                    prbs_bgc_pkg::ones_fill(tap_mask_reg), tap_mask_reg);
            else
                shift_next = stepped;
        end
        else if (stage_reg.start_req)
        begin
            shift_next          = 32'(masked);
            seed_count_next     = 3'd1;
            result_next.seeding = 1'b1;
        end
        else if (seed_count_reg < prbs_bgc_pkg::SEED_BYTES)
        begin
            shift_next          = {shift_reg[23:0], masked};
            seed_count_next     = seed_count_reg + 3'd1;
            result_next.seeding = 1'b1;
        end
        else
        begin
            // compare against prediction, saturating accumulate
            shift_next = stepped;
            errs       = prbs_bgc_pkg::popcount8(stepped[7:0] ^ masked);
            sum        = {1'b0, base_total} + 33'(errs);
            total_next = sum[32] ? '1 : sum[31:0];
        end

        result_next.data_byte   = shift_next[7:0] & prbs_bgc_pkg::BYTE_MASK;
        result_next.byte_errors = errs;
        result_next.error_total = total_next;
    end

    // Control and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            shift_reg        <= '0;
            seed_count_reg   <= '0;
            total_reg        <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
                stage_valid_reg <= 1'b1;
            else if (load)
                stage_valid_reg <= 1'b0;

            if (load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            if (load)
            begin
                shift_reg      <= shift_next;
                seed_count_reg <= seed_count_next;
                total_reg      <= total_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            stage_reg <= item;
        if (load)
            result_reg <= result_next;
    end

    // Assertions
    `PBGC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !result_valid_reg && !stage_valid_reg, "pipeline not empty in reset")
    `PBGC_ASSERT(a_seed_range, seed_count_reg <= prbs_bgc_pkg::SEED_BYTES, "seed count out of range")
    `PBGC_ASSERT(a_seed_no_errs, result_valid_reg && result_reg.seeding |-> result_reg.byte_errors == '0, "errors on seed byte")
    `PBGC_ASSERT(a_total_monotone, load && !stage_reg.start_req |=> total_reg >= $past(total_reg), "error total decreased")
    `PBGC_ASSERT(a_gen_no_seed, load && !check_mode_reg |=> !result_reg.seeding && result_reg.byte_errors == '0, "seed flag in generate mode")
    `PBGC_ASSERT(a_stage_hold, stage_valid_reg && !load |=> stage_valid_reg && $stable(stage_reg), "stalled stage lost")

endmodule
